>>> rtl/assert_macros.svh
// shared assertion macros, clocked on clk with reset rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("port check failed");

// next-cycle implication
`define CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("port check failed");

`endif

>>> rtl/spld_pkg.sv
package spld_pkg;

    localparam int LIST_LIMIT  = 100;
    localparam int MAX_OUT     = 25;
    localparam int STORE_DEPTH = 128;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int POS_W       = $clog2(LIST_LIMIT + 4) + 1;
    localparam int CNT_W       = $clog2(MAX_OUT + 1);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 10;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SCROLL_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCROLL_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLIP_SCREEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FLIP_ADJUST = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PARTITION   = 3'd4;

    localparam logic [8:0] FLIP_ADJUST_RST = 9'd439;
    localparam logic [8:0] Y_FLIP_BASE     = 9'd246;
    localparam logic [7:0] Y_FOLD_LIMIT    = 8'd240;
    localparam logic [7:0] Y_OFFSET        = 8'd16;
    localparam logic [8:0] X_BASE          = 9'd256;

    localparam logic [POS_W-1:0] LIMIT_POS = POS_W'(LIST_LIMIT);
    localparam logic [POS_W-1:0] ENTRY_STEP = POS_W'(4);
    localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_OUT);

endpackage

>>> rtl/sprite_list_position_decode_top.sv
// sprite attribute store and list walker. start with kind low stores one byte;
// busy stays low so writes can follow back to back. start with kind high
// runs a pass: busy rises the next cycle and the block takes no start until
// busy falls. a pass runs a setup step, then for each entry walked (up to 25
// entries) the states RD0 to RD3, ATTR, FLIPX, FLIPY and OUTX in turn, as set
// by the single read port of the sprite store (four byte reads per entry) and
// the one shared 9-bit adder that forms the positions in turn. each result is
// marked by result_valid, high for a single cycle; the receiver cannot stall
// it, so it must take every result as it comes. the final result of a pass
// shows up in the same cycle as busy falls. last marks the final result of a
// pass, and an empty range gives one result with empty_res and last high and
// all other fields zero. the store reads as zero after reset through per-byte
// valid flags, so no clearing sweep is needed. cfg_ready is always high; write
// configuration only while busy is low and no result is still to come.
module sprite_list_position_decode_top
    import spld_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // command channel
    input  logic                  start,
    output logic                  busy,
    input  logic                  kind,
    input  logic [6:0]            address,
    input  logic [7:0]            write_data,
    input  logic                  upper_half,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // result strobe and fields
    output logic                  result_valid,
    output logic [7:0]            tile_code,
    output logic [3:0]            color,
    output logic                  flip_x,
    output logic                  flip_y,
    output logic [8:0]            screen_x,
    output logic signed [8:0]     screen_y,
    output logic                  empty_res,
    output logic                  last
);

    // one-hot sequencer: setup, four byte reads, then x/y finishing steps
    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_SETUP = 10'b00_0000_0010,
        ST_RD0   = 10'b00_0000_0100,
        ST_RD1   = 10'b00_0000_1000,
        ST_RD2   = 10'b00_0001_0000,
        ST_RD3   = 10'b00_0010_0000,
        ST_ATTR  = 10'b00_0100_0000,
        ST_FLIPX = 10'b00_1000_0000,
        ST_FLIPY = 10'b01_0000_0000,
        ST_OUTX  = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [9:0] scroll_x_reg;
    logic [8:0] scroll_y_reg;
    logic       flip_screen_reg;
    logic [8:0] flip_adjust_reg;
    logic [7:0] partition_reg;

    // walk state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] finish_reg, finish_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // per-entry working registers
    logic [7:0] yoff_reg, yoff_next;
    logic [7:0] sy_reg, sy_next;
    logic [8:0] sx_reg, sx_next;
    logic [8:0] y_reg, y_next;
    logic [7:0] tile_reg, tile_next;
    logic [3:0] color_reg, color_next;
    logic       fy_reg, fy_next;

    // store valid flags (cleared at reset, so unwritten bytes read as zero)
    logic [STORE_DEPTH-1:0] valid_reg;
    logic                   rd_valid_reg;

    // output registers
    logic       result_valid_reg, result_valid_next;
    logic       out_load;
    logic [7:0] out_tile_next;
    logic [3:0] out_color_next;
    logic       out_fx_next, out_fy_next, out_empty_next, out_last_next;
    logic [8:0] out_x_next, out_y_next;

    // store ports
    logic              store_we;
    logic [ADDR_W-1:0] rd_addr;
    logic [1:0]        rd_off;
    logic [7:0]        ram_rdata;
    logic [7:0]        rd_byte;

    // shared adder: sum = a + b + cin (mod 512)
    logic [8:0] alu_a, alu_b, alu_sum;
    logic       alu_cin;

    logic              pass_accept;
    logic [7:0]        part_clamped;
    logic [POS_W-1:0]  pos_step;
    logic [CNT_W-1:0]  cnt_step;
    logic              walk_more;
    logic              y_fold;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    assign store_we    = start && !busy && !kind;
    assign pass_accept = start && !busy && kind;

    assign part_clamped = (partition_reg > LIST_LIMIT[7:0]) ? LIST_LIMIT[7:0] : partition_reg;

    // sprite byte store
    spld_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (address[ADDR_W-1:0]),
        .wdata (write_data),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // byte offset within the entry being read this cycle
    always_comb
    begin
        case (state_reg)
            ST_RD1:  rd_off = 2'd1;
            ST_RD2:  rd_off = 2'd2;
            ST_RD3:  rd_off = 2'd3;
            default: rd_off = 2'd0;
        endcase
    end

    assign rd_addr = pos_reg[ADDR_W-1:0] + {{(ADDR_W-2){1'b0}}, rd_off};
    assign rd_byte = rd_valid_reg ? ram_rdata : 8'd0;

    // shared adder operand selection
    always_comb
    begin
        alu_a   = 9'd0;
        alu_b   = 9'd0;
        alu_cin = 1'b0;
        case (state_reg)
            ST_SETUP:
            begin
                alu_a = {1'b0, scroll_y_reg[7:0]};
                alu_b = {1'b0, Y_OFFSET};
            end
            ST_RD1:
            begin
                // b0 - (scroll_y + 16), low byte kept
                alu_a   = {1'b0, rd_byte};
                alu_b   = {1'b1, ~yoff_reg};
                alu_cin = 1'b1;
            end
            ST_RD3:
            begin
                // b2 - scroll_x
                alu_a   = {1'b0, rd_byte};
                alu_b   = ~scroll_x_reg[8:0];
                alu_cin = 1'b1;
            end
            ST_ATTR:
            begin
                // attribute bit 7 adds 256
                alu_a = sx_reg;
                alu_b = {rd_byte[7], 8'd0};
            end
            ST_FLIPX:
            begin
                alu_a   = flip_adjust_reg;
                alu_b   = ~sx_reg;
                alu_cin = 1'b1;
            end
            ST_FLIPY:
            begin
                alu_a   = Y_FLIP_BASE;
                alu_b   = ~{1'b0, sy_reg};
                alu_cin = 1'b1;
            end
            ST_OUTX:
            begin
                alu_a   = X_BASE;
                alu_b   = ~sx_reg;
                alu_cin = 1'b1;
            end
            default:
            begin
                alu_a = 9'd0;
            end
        endcase
    end

    assign alu_sum = alu_a + alu_b + {8'd0, alu_cin};

    // signed y above 240 wraps down by 256 (toggle of the sign bit)
    assign y_fold = !y_reg[8] && (y_reg[7:0] > Y_FOLD_LIMIT);

    assign pos_step  = pos_reg + ENTRY_STEP;
    assign cnt_step  = cnt_reg + CNT_W'(1);
    assign walk_more = (pos_step < finish_reg) && (cnt_step < MAX_CNT);

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        pos_next          = pos_reg;
        finish_next       = finish_reg;
        cnt_next          = cnt_reg;
        yoff_next         = yoff_reg;
        sy_next           = sy_reg;
        sx_next           = sx_reg;
        y_next            = y_reg;
        tile_next         = tile_reg;
        color_next        = color_reg;
        fy_next           = fy_reg;
        result_valid_next = 1'b0;
        out_load          = 1'b0;
        out_tile_next     = 8'd0;
        out_color_next    = 4'd0;
        out_fx_next       = 1'b0;
        out_fy_next       = 1'b0;
        out_x_next        = 9'd0;
        out_y_next        = 9'd0;
        out_empty_next    = 1'b0;
        out_last_next     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (pass_accept)
                begin
                    // range: partition up to the limit, or zero up to partition
                    if (upper_half)
                    begin
                        pos_next    = POS_W'(part_clamped);
                        finish_next = LIMIT_POS;
                    end
                    else
                    begin
                        pos_next    = '0;
                        finish_next = POS_W'(part_clamped);
                    end
                    cnt_next   = '0;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                yoff_next = alu_sum[7:0];
                if (pos_reg >= finish_reg)
                begin
                    // empty range: single marker result
                    out_load          = 1'b1;
                    out_empty_next    = 1'b1;
                    out_last_next     = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
                else
                begin
                    state_next = ST_RD0;
                end
            end
            ST_RD0:
            begin
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                sy_next    = alu_sum[7:0];
                state_next = ST_RD2;
            end
            ST_RD2:
            begin
                tile_next  = rd_byte;
                state_next = ST_RD3;
            end
            ST_RD3:
            begin
                sx_next    = alu_sum;
                state_next = ST_ATTR;
            end
            ST_ATTR:
            begin
                sx_next    = alu_sum;
                color_next = rd_byte[3:0];
                fy_next    = rd_byte[5] ^ flip_screen_reg;
                state_next = ST_FLIPX;
            end
            ST_FLIPX:
            begin
                if (flip_screen_reg)
                begin
                    sx_next = alu_sum;
                end
                state_next = ST_FLIPY;
            end
            ST_FLIPY:
            begin
                y_next     = flip_screen_reg ? alu_sum : {1'b0, sy_reg};
                state_next = ST_OUTX;
            end
            ST_OUTX:
            begin
                out_load          = 1'b1;
                out_tile_next     = tile_reg;
                out_color_next    = color_reg;
                out_fx_next       = flip_screen_reg;
                out_fy_next       = fy_reg;
                out_x_next        = alu_sum;
                out_y_next        = {y_reg[8] ^ y_fold, y_reg[7:0]};
                out_last_next     = !walk_more;
                result_valid_next = 1'b1;
                pos_next          = pos_step;
                cnt_next          = cnt_step;
                state_next        = walk_more ? ST_RD0 : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
            valid_reg        <= '0;
            rd_valid_reg     <= 1'b0;
            scroll_x_reg     <= 10'd0;
            scroll_y_reg     <= 9'd0;
            flip_screen_reg  <= 1'b0;
            flip_adjust_reg  <= FLIP_ADJUST_RST;
            partition_reg    <= 8'd0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            rd_valid_reg     <= valid_reg[rd_addr];
            if (store_we)
            begin
                valid_reg[address[ADDR_W-1:0]] <= 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SCROLL_X:    scroll_x_reg    <= cfg_data;
                    REG_SCROLL_Y:    scroll_y_reg    <= cfg_data[8:0];
                    REG_FLIP_SCREEN: flip_screen_reg <= cfg_data[0];
                    REG_FLIP_ADJUST: flip_adjust_reg <= cfg_data[8:0];
                    REG_PARTITION:   partition_reg   <= cfg_data[7:0];
                    default:         ;
                endcase
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        finish_reg <= finish_next;
        cnt_reg    <= cnt_next;
        yoff_reg   <= yoff_next;
        sy_reg     <= sy_next;
        sx_reg     <= sx_next;
        y_reg      <= y_next;
        tile_reg   <= tile_next;
        color_reg  <= color_next;
        fy_reg     <= fy_next;
        if (out_load)
        begin
            tile_code   <= out_tile_next;
            color       <= out_color_next;
            flip_x      <= out_fx_next;
            flip_y      <= out_fy_next;
            screen_x    <= out_x_next;
            screen_y    <= out_y_next;
            empty_res   <= out_empty_next;
            last        <= out_last_next;
        end
    end

    // result strobe: one cycle per transfer
    assign result_valid = result_valid_reg;

endmodule

>>> rtl/spld_ram.sv
module spld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/spld_checker.sv
`include "assert_macros.svh"

module spld_checker
    import spld_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic                  kind,
    input  logic                  result_valid,
    input  logic [7:0]            tile_code,
    input  logic [8:0]            screen_x,
    input  logic signed [8:0]     screen_y,
    input  logic                  empty_res,
    input  logic                  last
);

    // busy only ever follows an accepted pass
    `CHK_SAME(a_busy_from_pass, !$past(busy) && busy, $past(start && kind))

    // a byte write never makes the block busy
    `CHK_NEXT(a_write_no_busy, start && !busy && !kind, !busy)

    // more results of the pass are still to come
    `CHK_SAME(a_mid_pass_busy, result_valid && !last, busy)

    // empty marker is a lone, zeroed result
    `CHK_SAME(a_empty_shape, result_valid && empty_res,
              last && (tile_code == 8'd0) && (screen_x == 9'd0) && (screen_y == 9'sd0))

endmodule

bind sprite_list_position_decode_top spld_checker u_spld_checker (.*);

>>> dv/sprite_list_position_decode_top_tb.sv
module sprite_list_position_decode_top_tb;
    import spld_pkg::*;

    // command codes carried on the kind field
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_PASS  = 1'b1;

    // indexes with no register behind them, writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // one list entry occupies four store bytes
    localparam int ENTRY_BYTES     = 4;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 11;
    // a byte write settles without a setup step, a pass begins with a setup step
    localparam int SETTLE_CYCLES   = 4;
    localparam int TAIL_CYCLES     = 16;
    // a time limit far beyond the slowest correct run
    localparam int TIMEOUT_UNITS   = 2_000_000;
    localparam int MAX_PRINTED     = 40;

    typedef struct packed {
        logic [7:0] tile;
        logic [3:0] color;
        logic       fx;
        logic       fy;
        logic [8:0] sx;
        logic [8:0] sy;
        logic       empty;
        logic       last;
    } sprite_result_t;

    // predicts the list walk and holds the sprites still to come
    class sprite_list_scoreboard;
        bit [7:0]       sprite_bytes [STORE_DEPTH];
        bit [9:0]       scroll_x;
        bit [8:0]       scroll_y;
        bit             flip_screen;
        bit [8:0]       flip_adjust;
        bit [7:0]       partition;
        sprite_result_t expected_sprites [$];
        int             mismatches;

        function new();
            foreach (sprite_bytes[i])
                sprite_bytes[i] = 8'h00;
            scroll_x    = '0;
            scroll_y    = '0;
            flip_screen = 1'b0;
            flip_adjust = FLIP_ADJUST_RST;
            partition   = '0;
            mismatches  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_SCROLL_X:    scroll_x    = val[9:0];
                REG_SCROLL_Y:    scroll_y    = val[8:0];
                REG_FLIP_SCREEN: flip_screen = val[0];
                REG_FLIP_ADJUST: flip_adjust = val[8:0];
                REG_PARTITION:   partition   = val[7:0];
                default: ;
            endcase
        endfunction

        function sprite_result_t decode_entry(int base);
            sprite_result_t r;
            logic [7:0]     b0;
            logic [7:0]     b2;
            logic [7:0]     attr;
            logic [7:0]     sy;
            logic [8:0]     sx;
            int             y;
            b0   = sprite_bytes[base % STORE_DEPTH];
            b2   = sprite_bytes[(base + 2) % STORE_DEPTH];
            attr = sprite_bytes[(base + 3) % STORE_DEPTH];
            sy   = b0 - Y_OFFSET - scroll_y[7:0];
            sx   = {1'b0, b2} - scroll_x[8:0] + {attr[7], 8'h00};
            r       = '0;
            r.tile  = sprite_bytes[(base + 1) % STORE_DEPTH];
            r.color = attr[3:0];
            r.fx    = flip_screen;
            r.fy    = attr[5] ^ flip_screen;
            if (flip_screen)
            begin
                sx = flip_adjust - sx;
                y  = int'(Y_FLIP_BASE) - int'(sy);
            end
            else
            begin
                y = int'(sy);
            end
            if (y > int'(Y_FOLD_LIMIT))
                y = y - 256;
            r.sx = X_BASE - sx;
            r.sy = y[8:0];
            return r;
        endfunction

        function void note_command(logic cmd, logic [6:0] addr, logic [7:0] data,
                                   logic upper);
            int             lim;
            int             range_lo;
            int             range_hi;
            int             count;
            sprite_result_t r;
            if (cmd == CMD_WRITE)
            begin
                sprite_bytes[addr] = data;
                return;
            end
            lim      = (int'(partition) > LIST_LIMIT) ? LIST_LIMIT : int'(partition);
            range_lo = upper ? lim : 0;
            range_hi = upper ? LIST_LIMIT : lim;
            count    = 0;
            for (int pos = range_lo; pos < range_hi && count < MAX_OUT; pos += ENTRY_BYTES)
            begin
                r      = decode_entry(pos);
                r.last = (pos + ENTRY_BYTES >= range_hi) || (count == MAX_OUT - 1);
                expected_sprites.push_back(r);
                count++;
            end
            if (count == 0)
            begin
                r       = '0;
                r.empty = 1'b1;
                r.last  = 1'b1;
                expected_sprites.push_back(r);
            end
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= MAX_PRINTED)
                $display("mismatch: %s", msg);
        endtask

        task check_result(sprite_result_t got);
            sprite_result_t want;
            if (expected_sprites.size() == 0)
            begin
                report($sformatf("sprite tile %0d with nothing outstanding", got.tile));
                return;
            end
            want = expected_sprites.pop_front();
            if (got.tile !== want.tile)
                report($sformatf("tile_code %0d want %0d", got.tile, want.tile));
            if (got.color !== want.color)
                report($sformatf("color %0d want %0d", got.color, want.color));
            if (got.fx !== want.fx)
                report($sformatf("flip_x %0d want %0d", got.fx, want.fx));
            if (got.fy !== want.fy)
                report($sformatf("flip_y %0d want %0d", got.fy, want.fy));
            if (got.sx !== want.sx)
                report($sformatf("screen_x %0d want %0d", got.sx, want.sx));
            if (got.sy !== want.sy)
                report($sformatf("screen_y %0d want %0d", $signed(got.sy), $signed(want.sy)));
            if (got.empty !== want.empty)
                report($sformatf("empty_res %0d want %0d", got.empty, want.empty));
            if (got.last !== want.last)
                report($sformatf("last %0d want %0d", got.last, want.last));
        endtask

        function int pending();
            return expected_sprites.size();
        endfunction
    endclass

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  start      = 1'b0;
    logic                  busy;
    logic                  kind       = CMD_WRITE;
    logic [6:0]            address    = '0;
    logic [7:0]            write_data = '0;
    logic                  upper_half = 1'b0;
    logic                  cfg_valid  = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index  = REG_SCROLL_X;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  result_valid;
    logic [7:0]            tile_code;
    logic [3:0]            color;
    logic                  flip_x;
    logic                  flip_y;
    logic [8:0]            screen_x;
    logic signed [8:0]     screen_y;
    logic                  empty_res;
    logic                  last;

    sprite_list_scoreboard sb = new();

    // chance in a hundred, drawn anew each time, that the sender idles once more before a command
    int sender_idle_pct = 0;
    // the receiver cannot hold results off, so the phase meant for receiver
    // stalls runs with no idling at all and the mixed phase keeps only the
    // sender part
    int idle_by_phase [4] = '{0, 72, 0, 37};

    sprite_list_position_decode_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .address      (address),
        .write_data   (write_data),
        .upper_half   (upper_half),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .tile_code    (tile_code),
        .color        (color),
        .flip_x       (flip_x),
        .flip_y       (flip_y),
        .screen_x     (screen_x),
        .screen_y     (screen_y),
        .empty_res    (empty_res),
        .last         (last)
    );

    always #2 clk = ~clk;

    // every strobed result is a transfer, taken at the edge that ends its cycle
    always @(posedge clk)
    begin
        sprite_result_t seen;
        if (rst_n && result_valid)
        begin
            seen.tile  = tile_code;
            seen.color = color;
            seen.fx    = flip_x;
            seen.fy    = flip_y;
            seen.sx    = screen_x;
            seen.sy    = screen_y;
            seen.empty = empty_res;
            seen.last  = last;
            sb.check_result(seen);
        end
    end

    // present one command, keeping start high so back to back commands can follow
    // without start dropping, and note it once the transfer has happened
    task automatic send_command(logic cmd, logic [6:0] addr, logic [7:0] data,
                                logic upper);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        kind       <= cmd;
        address    <= addr;
        write_data <= data;
        upper_half <= upper;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_command(cmd, addr, data, upper);
    endtask

    // one sprite entry: y byte, tile, x byte, attribute byte
    task automatic write_entry(int base, logic [7:0] b0, logic [7:0] b1,
                               logic [7:0] b2, logic [7:0] b3);
        send_command(CMD_WRITE, 7'(base),     b0, 1'($urandom_range(1)));
        send_command(CMD_WRITE, 7'(base + 1), b1, 1'($urandom_range(1)));
        send_command(CMD_WRITE, 7'(base + 2), b2, 1'($urandom_range(1)));
        send_command(CMD_WRITE, 7'(base + 3), b3, 1'($urandom_range(1)));
    endtask

    // a pass with random don't-care address and data
    task automatic run_pass(logic upper);
        send_command(CMD_PASS, 7'($urandom_range(127)), 8'($urandom_range(255)), upper);
    endtask

    // hold the sender off until every sprite is back and the walker is idle,
    // then give a trailing byte write time to land
    task automatic wait_idle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0 || busy !== 1'b0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // configuration transfer, only ever issued while the block is idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        sb.set_reg(idx, CFG_DATA_W'(val));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // pick one extreme or a value in between
    function automatic int pick_value(int lo_val, int hi_val);
        int roll;
        roll = $urandom_range(3);
        if (roll == 0)
            return lo_val;
        if (roll == 1)
            return hi_val;
        return $urandom_range(hi_val, lo_val);
    endfunction

    task automatic random_config();
        int roll;
        write_reg(REG_SCROLL_X, pick_value(0, 541));
        write_reg(REG_SCROLL_Y, pick_value(0, 256));
        write_reg(REG_FLIP_SCREEN, $urandom_range(1));
        write_reg(REG_FLIP_ADJUST, pick_value(0, 511));
        // mostly a partition inside the list, now and then one to be clamped
        roll = $urandom_range(9);
        if (roll < 2)
            write_reg(REG_PARTITION, $urandom_range(255, LIST_LIMIT + 1));
        else if (roll < 5)
            write_reg(REG_PARTITION, ENTRY_BYTES * $urandom_range(LIST_LIMIT / ENTRY_BYTES));
        else
            write_reg(REG_PARTITION, $urandom_range(LIST_LIMIT));
        if ($urandom_range(3) == 0)
            write_reg(REG_SPARE_LO + CFG_IDX_W'($urandom_range(2)), $urandom_range(1023));
    endtask

    initial
    begin
        int roll;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // store reads as zero straight out of reset; partition 0 leaves the
        // lower range empty and the upper one full
        sender_idle_pct = 0;
        run_pass(1'b0);
        run_pass(1'b1);

        // extreme entry bytes at the first, second and last entry of the list
        write_entry(0, 8'h00, 8'hff, 8'hff, 8'hff);
        write_entry(ENTRY_BYTES, 8'hff, 8'h00, 8'h00, 8'h20);
        write_entry(LIST_LIMIT - ENTRY_BYTES, 8'h10, 8'ha5, 8'h80, 8'h8f);
        send_command(CMD_WRITE, 7'h7f, 8'h5a, 1'b1);
        wait_idle();

        // partition above the list is clamped, so the upper range is empty;
        // a write to an unused index must leave everything alone
        write_reg(REG_PARTITION, 255);
        write_reg(REG_SCROLL_X, 541);
        write_reg(REG_SCROLL_Y, 256);
        write_reg(REG_SPARE_HI, 1023);
        run_pass(1'b1);
        run_pass(1'b0);
        wait_idle();

        // flipped screen; partition off the entry grid so the upper walk has
        // one entry that reaches past the range end
        write_reg(REG_FLIP_SCREEN, 1);
        write_reg(REG_FLIP_ADJUST, 0);
        write_reg(REG_PARTITION, LIST_LIMIT - 2);
        run_pass(1'b0);
        run_pass(1'b1);
        wait_idle();

        write_reg(REG_FLIP_ADJUST, 511);
        write_reg(REG_PARTITION, ENTRY_BYTES);
        write_reg(REG_SCROLL_Y, 16);
        write_reg(REG_SCROLL_X, 0);
        run_pass(1'b1);
        run_pass(1'b0);
        wait_idle();

        // random phases: mostly writes into the list area followed by passes
        // over fresh content, some writes outside the list as noise
        for (int ph = 0; ph < PHASES; ph++)
        begin
            random_config();
            sender_idle_pct = idle_by_phase[ph % 4];
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                roll = $urandom_range(99);
                if (roll < 8)
                    send_command(CMD_WRITE, 7'($urandom_range(127, LIST_LIMIT)),
                                 8'($urandom_range(255)), 1'($urandom_range(1)));
                else if (roll < 68)
                    send_command(CMD_WRITE, 7'($urandom_range(LIST_LIMIT + 3)),
                                 8'($urandom_range(255)), 1'($urandom_range(1)));
                else
                    run_pass(1'($urandom_range(1)));
                // now and then let the walker drain completely mid-phase
                if ($urandom_range(99) < 5)
                    wait_idle();
            end
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog against a hung handshake or missing results
    initial
    begin
        #(TIMEOUT_UNITS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
